@@ src/ile_pkg.sv @@
// Types and codes for the indexed list engine: request and result beats,
// actions, status codes and the command broadcast to the list cells.
// No dependencies.
package ile_pkg;

  localparam int unsigned IDX_W = 11;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_FIND   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FIND   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] pos;
  } cell_cmd_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  position;
    logic [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [4:0]  entry_count;
  } out_beat_t;

endpackage

@@ src/indexed_list_engine.sv @@
// Indexed list engine: an ordered list of up to DEPTH words with append,
// insert, remove and find at a position. One request is taken per clock while
// in_stall is low: on insert and remove the list cells shift in the cycle the
// request is accepted, and the result is registered for the output. A two-beat
// result buffer lets requests keep flowing while a result waits; in_stall rises
// only when both result beats are held by a stalled output. Entries come up
// undefined after reset; only entries below the count are ever read.
// Depends on ile_pkg and ile_cell.
module indexed_list_engine #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ile_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ile_pkg::out_beat_t out_data
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned RD_N = (DEPTH < 16) ? DEPTH : 16;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  ile_pkg::out_beat_t out_r;
  ile_pkg::out_beat_t out_nxt;
  ile_pkg::out_beat_t skid_r;
  ile_pkg::out_beat_t skid_nxt;
  logic               out_v_r;
  logic               out_v_nxt;
  logic               skid_v_r;
  logic               skid_v_nxt;

  logic                         accept;
  logic                         take;
  logic                         full;
  logic [ile_pkg::IDX_W-1:0]    pos_ext;
  logic [ile_pkg::IDX_W-1:0]    cnt_ext;
  ile_pkg::cell_cmd_t           cmd;
  ile_pkg::status_t             res_st;
  ile_pkg::out_beat_t           res;
  logic [DATA_WIDTH-1:0]        load_val;
  logic [DATA_WIDTH-1:0]        cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]        cell_rd   [DEPTH];
  logic [DATA_WIDTH-1:0]        rd_any;

  assign in_stall  = skid_v_r;
  assign accept    = in_valid && !in_stall;
  assign take      = out_v_r && !out_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign full     = (count_r == CW'(DEPTH));
  assign pos_ext  = ile_pkg::IDX_W'(in_data.position);
  assign cnt_ext  = ile_pkg::IDX_W'(count_r);
  assign load_val = DATA_WIDTH'(in_data.value);

  // decode the request into a cell command and the next count
  always_comb begin
    cmd.op    = ile_pkg::OP_HOLD;
    cmd.pos   = pos_ext;
    count_nxt = count_r;
    res_st    = ile_pkg::ST_DONE;
    unique case (ile_pkg::action_t'(in_data.action))
      ile_pkg::ACT_APPEND, ile_pkg::ACT_INSERT: begin
        if (full) begin
          res_st = ile_pkg::ST_FULL;
        end else begin
          cmd.op = ile_pkg::OP_INSERT;
          if (in_data.action == ile_pkg::ACT_APPEND || pos_ext > cnt_ext) begin
            cmd.pos = cnt_ext;
          end
          count_nxt = count_r + CW'(1);
        end
      end
      ile_pkg::ACT_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          res_st = ile_pkg::ST_RANGE;
        end else begin
          cmd.op    = ile_pkg::OP_REMOVE;
          count_nxt = count_r - CW'(1);
        end
      end
      ile_pkg::ACT_FIND: begin
        if (pos_ext >= cnt_ext) begin
          res_st = ile_pkg::ST_RANGE;
        end else begin
          cmd.op = ile_pkg::OP_FIND;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      cmd.op    = ile_pkg::OP_HOLD;
      count_nxt = count_r;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (g == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    ile_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX       (g)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .load_data (load_val),
      .left_data (left_d),
      .right_data(right_d),
      .data      (cell_data[g]),
      .rd_data   (cell_rd[g])
    );
  end

  // only the cells a 4-bit position can reach take part in find
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < RD_N; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  assign res = '{read_value: 32'(rd_any), status: res_st, entry_count: 5'(count_nxt)};

  // two-beat result buffer
  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (accept) begin
      if (out_v_r && !take) begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end else begin
        out_nxt   = res;
        out_v_nxt = 1'b1;
      end
    end else if (take) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

@@ src/ile_cell.sv @@
// One list slot of the indexed list engine: holds an entry and shifts it
// to or from its neighbors on insert and remove commands.
// Depends on ile_pkg.
module ile_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk,
  input  ile_pkg::cell_cmd_t    cmd,
  input  logic [DATA_WIDTH-1:0] load_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd_data
);

  localparam logic [ile_pkg::IDX_W-1:0] MY_IDX = ile_pkg::IDX_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    rd_data  = '0;
    unique case (cmd.op)
      ile_pkg::OP_INSERT: begin
        if (MY_IDX > cmd.pos) begin
          data_nxt = left_data;
        end else if (MY_IDX == cmd.pos) begin
          data_nxt = load_data;
        end
      end
      ile_pkg::OP_REMOVE: begin
        if (MY_IDX >= cmd.pos) begin
          data_nxt = right_data;
        end
      end
      ile_pkg::OP_FIND: begin
        if (MY_IDX == cmd.pos) begin
          rd_data = data_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
